// File: rtl/mavg_pkg.sv
// ----------------------------------------------------------------------------
// mavg_pkg
// Shared widths, payload types and the reciprocal table of the
// moving-average filter.
// ----------------------------------------------------------------------------
package mavg_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int WLEN_W      = 4;
    localparam int MIN_WINDOW  = 3;
    localparam int RECIP_W     = 31;
    localparam int RECIP_SHIFT = 32;

    localparam logic [WLEN_W-1:0] WINDOW_RESET = 4'd3;

    typedef logic [WLEN_W-1:0]  wlen_t;
    typedef logic [RECIP_W-1:0] recip_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       frame_start;
    } sample_req_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] average;
    } average_t;

    typedef struct packed {
        wlen_t window_length;
    } cfg_t;

    // ceil(2^32 / w); exact floor division for magnitudes below 2^20
    function automatic recip_t recip_of(input wlen_t w);
        recip_t r;
        case (w)
            4'd3:    r = 31'h55555556;
            4'd4:    r = 31'h40000000;
            4'd5:    r = 31'h33333334;
            4'd6:    r = 31'h2AAAAAAB;
            4'd7:    r = 31'h24924925;
            4'd8:    r = 31'h20000000;
            4'd9:    r = 31'h1C71C71D;
            4'd10:   r = 31'h1999999A;
            4'd11:   r = 31'h1745D175;
            4'd12:   r = 31'h15555556;
            4'd13:   r = 31'h13B13B14;
            4'd14:   r = 31'h12492493;
            4'd15:   r = 31'h11111112;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/mavg_chan_if.sv
// ----------------------------------------------------------------------------
// mavg_chan_if
// Valid/ready channel carrying one payload per request.
// ----------------------------------------------------------------------------
interface mavg_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/mavg_cell.sv
// ----------------------------------------------------------------------------
// mavg_cell
// One window position: holds a sample, passes it to the next cell on each
// accepted request and offers its sign-extended term while inside the window.
// ----------------------------------------------------------------------------
module mavg_cell #(
    parameter int INDEX = 0,
    parameter int SUM_W = 20
) (
    input  logic                                 clk,
    input  logic                                 shift,
    input  logic signed [mavg_pkg::SAMPLE_W-1:0] prev_sample,
    input  mavg_pkg::wlen_t                      window_length,
    output logic signed [mavg_pkg::SAMPLE_W-1:0] sample,
    output logic signed [SUM_W-1:0]              term
);

    logic signed [mavg_pkg::SAMPLE_W-1:0] sample_reg;
    logic signed [mavg_pkg::SAMPLE_W-1:0] sample_next;

    always_comb
    begin
        sample_next = shift ? prev_sample : sample_reg;
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
    end

    assign sample = sample_reg;
    assign term   = (mavg_pkg::WLEN_W'(INDEX) < window_length) ? SUM_W'(sample_reg) : '0;

endmodule

// File: rtl/mavg_tree.sv
// ----------------------------------------------------------------------------
// mavg_tree
// Registered binary adder tree, one level per stage, with a valid/ready
// handshake that lets bubbles collapse.
// ----------------------------------------------------------------------------
module mavg_tree #(
    parameter int LEVELS = 4,
    parameter int SUM_W  = 20
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [SUM_W-1:0] leaves [1 << LEVELS],
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [SUM_W-1:0] sum
);

    localparam int LEAVES = 1 << LEVELS;

    logic                    valid_reg  [LEVELS];
    logic                    valid_next [LEVELS];
    logic                    level_en   [LEVELS];
    logic                    node_en    [1:LEAVES-1];
    logic signed [SUM_W-1:0] node_reg   [1:LEAVES-1];
    logic signed [SUM_W-1:0] node_next  [1:LEAVES-1];

    // depth 0 is the root; a level moves when it is empty or the one nearer the root moves
    always_comb
    begin
        level_en[0] = !valid_reg[0] || out_ready;
        for (int d = 1; d < LEVELS; d++)
        begin
            level_en[d] = !valid_reg[d] || level_en[d-1];
        end
        for (int d = 0; d < LEVELS; d++)
        begin
            if (d == LEVELS - 1)
                valid_next[d] = level_en[d] ? in_valid : valid_reg[d];
            else
                valid_next[d] = level_en[d] ? valid_reg[d+1] : valid_reg[d];
        end
    end

    for (genvar i = 1; i < LEAVES; i++)
    begin : g_node
        localparam int DEPTH = $clog2(i + 1) - 1;

        assign node_en[i] = level_en[DEPTH];

        if (2 * i >= LEAVES)
        begin : g_from_leaves
            assign node_next[i] = leaves[2*i-LEAVES] + leaves[2*i+1-LEAVES];
        end
        else
        begin : g_from_nodes
            assign node_next[i] = node_reg[2*i] + node_reg[2*i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < LEVELS; d++)
            begin
                valid_reg[d] <= 1'b0;
            end
        end
        else
        begin
            for (int d = 0; d < LEVELS; d++)
            begin
                valid_reg[d] <= valid_next[d];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 1; i < LEAVES; i++)
        begin
            if (node_en[i])
                node_reg[i] <= node_next[i];
        end
    end

    assign in_ready  = level_en[LEVELS-1];
    assign out_valid = valid_reg[0];
    assign sum       = node_reg[1];

endmodule

// File: rtl/mavg_div.sv
// ----------------------------------------------------------------------------
// mavg_div
// Signed division of the window sum by the window length, truncated toward
// zero: magnitude, reciprocal multiply, sign restore into the output register.
// ----------------------------------------------------------------------------
module mavg_div #(
    parameter int SUM_W = 20
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  mavg_pkg::wlen_t                      window_length,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [SUM_W-1:0]              sum,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [mavg_pkg::SAMPLE_W-1:0] average
);

    localparam int PROD_W = SUM_W + mavg_pkg::RECIP_W;
    localparam int QUOT_W = PROD_W - mavg_pkg::RECIP_SHIFT;

    logic                 mag_valid_reg, mag_valid_next;
    logic                 prod_valid_reg, prod_valid_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 mag_en, prod_en, out_en;

    logic [SUM_W-1:0]     mag_reg, mag_next;
    logic                 mag_neg_reg, mag_neg_next;
    mavg_pkg::recip_t     recip_reg, recip_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic                 prod_neg_reg, prod_neg_next;
    logic [QUOT_W-1:0]    quot;
    logic [QUOT_W-1:0]    quot_signed;
    logic signed [mavg_pkg::SAMPLE_W-1:0] average_reg, average_next;

    always_comb
    begin
        out_en  = !out_valid_reg || out_ready;
        prod_en = !prod_valid_reg || out_en;
        mag_en  = !mag_valid_reg || prod_en;

        mag_valid_next  = mag_en  ? in_valid       : mag_valid_reg;
        prod_valid_next = prod_en ? mag_valid_reg  : prod_valid_reg;
        out_valid_next  = out_en  ? prod_valid_reg : out_valid_reg;

        // magnitude of the most negative sum wraps to the right unsigned value
        mag_neg_next = mag_en ? sum[SUM_W-1] : mag_neg_reg;
        mag_next     = mag_reg;
        recip_next   = recip_reg;
        if (mag_en)
        begin
            mag_next   = sum[SUM_W-1] ? (~SUM_W'(sum) + 1'b1) : SUM_W'(sum);
            recip_next = mavg_pkg::recip_of(window_length);
        end

        prod_next     = prod_en ? (PROD_W'(mag_reg) * PROD_W'(recip_reg)) : prod_reg;
        prod_neg_next = prod_en ? mag_neg_reg : prod_neg_reg;

        quot         = prod_reg[PROD_W-1:mavg_pkg::RECIP_SHIFT];
        quot_signed  = prod_neg_reg ? (~quot + 1'b1) : quot;
        average_next = out_en ? quot_signed[mavg_pkg::SAMPLE_W-1:0] : average_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            mag_valid_reg  <= mag_valid_next;
            prod_valid_reg <= prod_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        mag_neg_reg  <= mag_neg_next;
        recip_reg    <= recip_next;
        prod_reg     <= prod_next;
        prod_neg_reg <= prod_neg_next;
        average_reg  <= average_next;
    end

    assign in_ready  = mag_en;
    assign out_valid = out_valid_reg;
    assign average   = average_reg;

endmodule

// File: rtl/moving_average_filter.sv
// ----------------------------------------------------------------------------
// moving_average_filter
// Boxcar moving average over signed 16-bit samples with a configurable
// window length of 3 to MAX_WINDOW.
// ----------------------------------------------------------------------------
//   channel    dir   payload                           notes
//   samples    in    sample (s16), frame_start         one request per sample
//   averages   out   average (s16)                     only for full windows
//   cfg        in    window_length (u4)                always ready
//
// Sustains one sample per cycle while averages.ready stays high; the rate is
// set by the sample cell chain, which shifts once per accepted request.
// From accept to result the data passes the cell load, one adder tree level per
// register, the magnitude, the multiply and the output register.
// Reset clears the fill count, the pipeline valids and sets the window to 3;
// the sample cells are not cleared. Stalls collapse bubbles stage by stage.
// ----------------------------------------------------------------------------
module moving_average_filter #(
    parameter int MAX_WINDOW = 10
) (
    input logic   clk,
    input logic   rst_n,
    mavg_chan_if.sink   samples,
    mavg_chan_if.source averages,
    mavg_chan_if.sink   cfg
);

    localparam int LEVELS = $clog2(MAX_WINDOW);
    localparam int LEAVES = 1 << LEVELS;
    localparam int SUM_W  = mavg_pkg::SAMPLE_W + LEVELS;
    localparam int FILL_W = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W  = (FILL_W > mavg_pkg::WLEN_W) ? FILL_W : mavg_pkg::WLEN_W;

    mavg_pkg::wlen_t   window_length_reg, window_length_next;
    logic [FILL_W-1:0] fill_count_reg, fill_count_next;
    logic [FILL_W-1:0] fill_base;
    logic              cells_valid_reg, cells_valid_next;
    logic              accept;
    logic              window_ok;
    logic              emit;
    logic              tree_ready;
    logic              tree_valid;
    logic              div_ready;

    logic signed [mavg_pkg::SAMPLE_W-1:0] chain [MAX_WINDOW];
    logic signed [SUM_W-1:0]              leaves [LEAVES];
    logic signed [SUM_W-1:0]              window_sum;
    mavg_pkg::sample_req_t                req;

    assign req       = samples.data;
    assign cfg.ready = 1'b1;

    // the cells hold one window at a time; advance them only when it moves on
    assign samples.ready = !cells_valid_reg || tree_ready;
    assign accept        = samples.valid && samples.ready;

    always_comb
    begin
        window_length_next = (cfg.valid && cfg.ready) ? cfg.data.window_length
                                                      : window_length_reg;

        fill_base       = req.frame_start ? '0 : fill_count_reg;
        fill_count_next = fill_count_reg;
        if (accept)
        begin
            fill_count_next = (CMP_W'(fill_base) < CMP_W'(MAX_WINDOW))
                              ? fill_base + 1'b1 : fill_base;
        end

        window_ok = (CMP_W'(window_length_reg) >= CMP_W'(mavg_pkg::MIN_WINDOW))
                 && (CMP_W'(window_length_reg) <= CMP_W'(MAX_WINDOW));
        emit      = window_ok && (CMP_W'(fill_count_next) >= CMP_W'(window_length_reg));

        cells_valid_next = samples.ready ? (accept && emit) : cells_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= mavg_pkg::WINDOW_RESET;
            fill_count_reg    <= '0;
            cells_valid_reg   <= 1'b0;
        end
        else
        begin
            window_length_reg <= window_length_next;
            fill_count_reg    <= fill_count_next;
            cells_valid_reg   <= cells_valid_next;
        end
    end

    for (genvar k = 0; k < LEAVES; k++)
    begin : g_cell
        if (k < MAX_WINDOW)
        begin : g_live
            mavg_cell #(
                .INDEX (k),
                .SUM_W (SUM_W)
            ) u_cell (
                .clk           (clk),
                .shift         (accept),
                .prev_sample   ((k == 0) ? req.sample : chain[(k == 0) ? 0 : k-1]),
                .window_length (window_length_reg),
                .sample        (chain[k]),
                .term          (leaves[k])
            );
        end
        else
        begin : g_pad
            assign leaves[k] = '0;
        end
    end

    mavg_tree #(
        .LEVELS (LEVELS),
        .SUM_W  (SUM_W)
    ) u_tree (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cells_valid_reg),
        .in_ready  (tree_ready),
        .leaves    (leaves),
        .out_valid (tree_valid),
        .out_ready (div_ready),
        .sum       (window_sum)
    );

    mavg_div #(
        .SUM_W (SUM_W)
    ) u_div (
        .clk           (clk),
        .rst_n         (rst_n),
        .window_length (window_length_reg),
        .in_valid      (tree_valid),
        .in_ready      (div_ready),
        .sum           (window_sum),
        .out_valid     (averages.valid),
        .out_ready     (averages.ready),
        .average       (averages.data.average)
    );

    // a frame start restarts the count at one
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.frame_start |=> fill_count_reg == FILL_W'(1))
    else $error("fill count did not restart on frame start");

    // the count saturates at the deepest window
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && !req.frame_start && (CMP_W'(fill_count_reg) == CMP_W'(MAX_WINDOW))
        |=> CMP_W'(fill_count_reg) == CMP_W'(MAX_WINDOW))
    else $error("fill count left saturation");

    // input backpressure only while the cells hold an unsummed window
    assert property (@(posedge clk) disable iff (!rst_n)
        !samples.ready |-> cells_valid_reg && !tree_ready)
    else $error("input stalled without a held window");

    // a held window stays held until the tree takes it
    assert property (@(posedge clk) disable iff (!rst_n)
        cells_valid_reg && !tree_ready |=> cells_valid_reg)
    else $error("held window dropped");

endmodule

// File: sim/tb_moving_average_filter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_moving_average_filter
// Drives sample requests and window-length writes into the moving-average
// filter and checks every average against a cycle-free predictor of the
// boxcar sum with truncating division. The tests cover field extremes,
// negative sums, frame restarts and out-of-range windows. Randomized phases
// vary the sender gaps and the receiver stalls, and one test holds off the
// receiver long enough to back up the pipeline.
// ----------------------------------------------------------------------------
module tb_moving_average_filter;

    localparam int MAX_WINDOW     = 10;
    localparam int LATENCY        = $clog2(MAX_WINDOW) + 4;
    localparam int SETTLE_CYCLES  = LATENCY + 5;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SEGMENT_ITEMS  = 40;
    localparam int HOLD_CYCLES    = 150;

    logic clk;
    logic rst_n;

    mavg_chan_if #(.payload_t(mavg_pkg::sample_req_t)) samples_if ();
    mavg_chan_if #(.payload_t(mavg_pkg::average_t))    averages_if ();
    mavg_chan_if #(.payload_t(mavg_pkg::cfg_t))        cfg_if ();

    moving_average_filter #(
        .MAX_WINDOW(MAX_WINDOW)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (samples_if),
        .averages (averages_if),
        .cfg      (cfg_if)
    );

    // predictor state
    logic signed [mavg_pkg::SAMPLE_W-1:0] window_hist [MAX_WINDOW];
    int                                   fill_cnt;
    mavg_pkg::wlen_t                      cur_window;
    logic signed [mavg_pkg::SAMPLE_W-1:0] pending_averages [$];

    // stimulus controls
    int send_idle_pct;
    int stall_pct;
    int hold_until = 0;
    int recv_cycles = 0;

    // bookkeeping
    int mismatches = 0;
    int samples_sent;
    int averages_checked = 0;
    int windows_written;
    int stall_cycles = 0;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Shift the sample into the history and queue the average it produces.
    task automatic apply_sample(input logic signed [mavg_pkg::SAMPLE_W-1:0] s,
                                input logic fs);
        int                                   k;
        int                                   w;
        int                                   sum;
        int                                   avg;
        logic signed [mavg_pkg::SAMPLE_W-1:0] avg16;
        w = cur_window;
        if (fs)
            fill_cnt = 0;
        for (k = MAX_WINDOW - 1; k > 0; k--)
            window_hist[k] = window_hist[k-1];
        window_hist[0] = s;
        if (fill_cnt < MAX_WINDOW)
            fill_cnt++;
        if (w >= mavg_pkg::MIN_WINDOW && w <= MAX_WINDOW && fill_cnt >= w)
        begin
            sum = 0;
            for (k = 0; k < w; k++)
                sum += window_hist[k];
            // int division truncates toward zero
            avg   = sum / w;
            avg16 = avg[mavg_pkg::SAMPLE_W-1:0];
            pending_averages.push_back(avg16);
        end
    endtask

    task automatic send_sample(input logic signed [mavg_pkg::SAMPLE_W-1:0] s,
                               input logic fs);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            samples_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        samples_if.valid            <= 1'b1;
        samples_if.data.sample      <= s;
        samples_if.data.frame_start <= fs;
        do
            @(posedge clk);
        while (!samples_if.ready);
        apply_sample(s, fs);
        samples_sent++;
    endtask

    task automatic wait_for_drain();
        while (pending_averages.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Drop the sample request, drain, then write the window length.
    task automatic write_window(input mavg_pkg::wlen_t w);
        samples_if.valid <= 1'b0;
        wait_for_drain();
        cfg_if.valid              <= 1'b1;
        cfg_if.data.window_length <= w;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        cur_window = w;
        windows_written++;
    endtask

    function automatic logic signed [mavg_pkg::SAMPLE_W-1:0] rand_sample();
        int v;
        case ($urandom_range(7))
            0: v = 32767;
            1: v = -32768;
            2: v = int'($urandom_range(16)) - 8;
            default: v = $urandom;
        endcase
        return v[mavg_pkg::SAMPLE_W-1:0];
    endfunction

    function automatic mavg_pkg::wlen_t pick_window();
        if ($urandom_range(5) == 0)
        begin
            if ($urandom_range(1) == 0)
                return mavg_pkg::wlen_t'($urandom_range(mavg_pkg::MIN_WINDOW - 1));
            return mavg_pkg::wlen_t'($urandom_range(15, MAX_WINDOW + 1));
        end
        return mavg_pkg::wlen_t'($urandom_range(MAX_WINDOW, mavg_pkg::MIN_WINDOW));
    endfunction

    task automatic run_segment(input mavg_pkg::wlen_t w, input int n);
        int  i;
        int  fs_burst;
        logic fs;
        write_window(w);
        fs_burst = 0;
        for (i = 0; i < n; i++)
        begin
            // mostly long frames, now and then a run of back-to-back restarts
            if (fs_burst > 0)
            begin
                fs = 1'b1;
                fs_burst--;
            end
            else if ($urandom_range(29) == 0)
            begin
                fs       = 1'b1;
                fs_burst = $urandom_range(3);
            end
            else
                fs = ($urandom_range(19) == 0);
            send_sample(rand_sample(), fs);
        end
    endtask

    // Window 3 from reset: full-scale sums and a restart before the window fills.
    task automatic test_extremes();
        send_sample(16'sh7FFF, 1'b1);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b1);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sd1, 1'b1);
        send_sample(-16'sd2, 1'b0);
    endtask

    // Negative sums on the power-of-two windows truncate, not floor.
    task automatic test_truncation();
        int i;
        write_window(4'd4);
        send_sample(-16'sd1, 1'b1);
        send_sample(-16'sd2, 1'b0);
        send_sample(-16'sd3, 1'b0);
        send_sample(-16'sd3, 1'b0);
        write_window(4'd8);
        send_sample(-16'sd1, 1'b1);
        for (i = 0; i < 6; i++)
            send_sample(-16'sd1, 1'b0);
        send_sample(-16'sd2, 1'b0);
    endtask

    // Fill count carries over a window change; out-of-range windows stay silent.
    task automatic test_window_change();
        write_window(4'd10);
        send_sample(16'sd1234, 1'b0);
        send_sample(-16'sd4321, 1'b0);
        write_window(4'd11);
        send_sample(16'sd77, 1'b0);
        write_window(4'd0);
        send_sample(-16'sd77, 1'b0);
        write_window(4'd2);
        send_sample(16'sd5, 1'b0);
        write_window(4'd15);
        send_sample(16'sh7FFF, 1'b1);
    endtask

    task automatic test_idle_phase(input int send_pct, input int recv_pct, input bit edges);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
        run_segment(edges ? 4'd3 : pick_window(), SEGMENT_ITEMS);
        run_segment(edges ? 4'd10 : pick_window(), SEGMENT_ITEMS);
        run_segment(pick_window(), SEGMENT_ITEMS);
    endtask

    // Hold off the receiver while samples keep coming, so the input stalls.
    task automatic test_backpressure();
        int i;
        send_idle_pct = 0;
        stall_pct     = 0;
        write_window(4'd5);
        hold_until = recv_cycles + HOLD_CYCLES;
        for (i = 0; i < 60; i++)
            send_sample(rand_sample(), (i == 0));
        samples_if.valid <= 1'b0;
        wait_for_drain();
    endtask

    // receiver: count its own cycles, hold off until the hold mark is passed
    always @(posedge clk)
    begin
        recv_cycles++;
        if (recv_cycles <= hold_until)
            averages_if.ready <= 1'b0;
        else
            averages_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && averages_if.valid && averages_if.ready)
        begin
            averages_checked++;
            if (pending_averages.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected average %0d", $time,
                             $signed(averages_if.data.average));
            end
            else if (averages_if.data.average !== pending_averages[0])
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: average mismatch, expected %0d got %0d", $time,
                             pending_averages[0], $signed(averages_if.data.average));
                void'(pending_averages.pop_front());
            end
            else
                void'(pending_averages.pop_front());
        end
    end

    always @(posedge clk)
    begin
        if ((samples_if.valid && samples_if.ready) ||
            (averages_if.valid && averages_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        int k;
        rst_n                       = 1'b0;
        samples_if.valid            = 1'b0;
        samples_if.data             = '0;
        cfg_if.valid                = 1'b0;
        cfg_if.data                 = '0;
        send_idle_pct               = 0;
        stall_pct                   = 0;
        samples_sent                = 0;
        windows_written             = 0;
        fill_cnt                    = 0;
        cur_window                  = mavg_pkg::WINDOW_RESET;
        for (k = 0; k < MAX_WINDOW; k++)
            window_hist[k] = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_truncation();
        test_window_change();
        test_idle_phase(0, 0, 1'b1);
        test_idle_phase(85, 0, 1'b0);
        test_idle_phase(0, 85, 1'b0);
        test_idle_phase(35, 35, 1'b0);
        test_backpressure();

        samples_if.valid <= 1'b0;
        wait_for_drain();

        $display("Sent %0d samples over %0d window writes; checked %0d averages.",
                 samples_sent, windows_written, averages_checked);
        $display("Mismatches: %0d, averages still outstanding: %0d.",
                 mismatches, pending_averages.size());
        if (mismatches == 0 && pending_averages.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
